// ===== design/rtte_pkg.sv =====
package rtte_pkg;

    // Default width of the stored estimator times (srtt, rttvar, mrto, erto), in milliseconds
    localparam int TIME_BITS_DEFAULT = 20;

    localparam int TICK_BITS   = 16;
    localparam int MARGIN_BITS = 10;
    localparam int FLOOR_BITS  = 12;
    localparam int CAP_BITS    = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;

    // Backoff factor 1.4142 in Q16
    localparam int BACKOFF_BITS = 17;
    localparam logic [BACKOFF_BITS-1:0] BACKOFF_Q16 = 17'd92682;

    // Reset values
    localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 10'd200;
    localparam logic [FLOOR_BITS-1:0]  FLOOR_RESET  = 12'd250;
    localparam logic [CAP_BITS-1:0]    CAP_RESET    = 16'd10000;
    localparam logic [CAP_BITS-1:0]    ERTO_RESET   = 16'd3000;
    localparam logic [FLOOR_BITS-1:0]  MRTO_RESET   = 12'd250;

    typedef enum logic [0:0] {
        CMD_SAMPLE  = 1'b0,
        CMD_BACKOFF = 1'b1
    } cmd_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_RTO_MARGIN   = 2'd0,
        CFG_ERTO_FLOOR   = 2'd1,
        CFG_ERTO_CAP     = 2'd2,
        CFG_INITIAL_ERTO = 2'd3
    } cfg_index_t;

endpackage

// ===== design/rtte_update.sv =====
module rtte_update #(
    parameter int TIME_BITS = rtte_pkg::TIME_BITS_DEFAULT
) (
    input  rtte_pkg::cmd_t                      cmd,
    input  logic                                session_open,
    input  logic                                echo_present,
    input  logic [rtte_pkg::TICK_BITS-1:0]      echo_ticks,
    input  logic [rtte_pkg::TICK_BITS-1:0]      now_ticks,
    input  logic [TIME_BITS-1:0]                srtt,
    input  logic [TIME_BITS-1:0]                rttvar,
    input  logic [TIME_BITS-1:0]                mrto,
    input  logic [TIME_BITS-1:0]                erto,
    input  logic [rtte_pkg::TICK_BITS-1:0]      last_echo,
    input  logic [rtte_pkg::MARGIN_BITS-1:0]    rto_margin,
    input  logic [rtte_pkg::FLOOR_BITS-1:0]     erto_floor,
    input  logic [rtte_pkg::CAP_BITS-1:0]       erto_cap,
    output logic [TIME_BITS-1:0]                srtt_next,
    output logic [TIME_BITS-1:0]                rttvar_next,
    output logic [TIME_BITS-1:0]                mrto_next,
    output logic [TIME_BITS-1:0]                erto_next,
    output logic [rtte_pkg::TICK_BITS-1:0]      last_echo_next,
    output logic                                sample_used
);
    import rtte_pkg::*;

    localparam int T = TIME_BITS;

    logic [TICK_BITS-1:0] ticks;
    logic                 sample_ok;
    logic                 rtt_ok;
    logic [T-1:0]         rtt;
    logic [T-1:0]         delta;
    logic [T+1:0]         var_sum;
    logic [T+2:0]         srtt_sum;
    logic [T-1:0]         srtt_s;
    logic [T-1:0]         var_s;
    logic [T+2:0]         mrto_sum;
    logic [T-1:0]         mrto_s;
    logic [T-1:0]         erto_s;
    logic [T+16:0]        prod;
    logic [T:0]           boosted;
    logic [T:0]           capped;
    logic [T:0]           backed;

    // Sample path: 16-bit wrapping tick difference, 4 ms per tick
    assign ticks  = now_ticks - echo_ticks;
    assign rtt_ok = ~ticks[TICK_BITS-1];
    assign rtt    = T'({ticks[TICK_BITS-2:0], 2'b00});

    assign delta    = (srtt >= rtt) ? (srtt - rtt) : (rtt - srtt);
    assign var_sum  = {rttvar, 1'b0} + (T+2)'(rttvar) + (T+2)'(delta);
    assign srtt_sum = {srtt, 3'b000} - (T+3)'(srtt) + (T+3)'(rtt);

    // Zero smoothed time means no estimate yet: seed from this sample
    assign srtt_s = (srtt == '0) ? rtt : srtt_sum[T+2:3];
    assign var_s  = (srtt == '0) ? (rtt >> 1) : var_sum[T+1:2];

    assign mrto_sum = (T+3)'(srtt_s) + {1'b0, var_s, 2'b00} + (T+3)'(rto_margin);
    assign mrto_s   = (|mrto_sum[T+2:T]) ? '1 : mrto_sum[T-1:0];
    assign erto_s   = (mrto_s > T'(erto_floor)) ? mrto_s : T'(erto_floor);

    // Backoff path: erto * 1.4142, capped, then no lower than mrto
    assign prod    = (T+17)'(erto) * (T+17)'(BACKOFF_Q16);
    assign boosted = prod[T+16:16];
    assign capped  = (boosted < (T+1)'(erto_cap)) ? boosted : (T+1)'(erto_cap);
    assign backed  = (capped > (T+1)'(mrto)) ? capped : (T+1)'(mrto);

    assign sample_ok = (cmd == CMD_SAMPLE) && session_open && echo_present
                       && (echo_ticks != last_echo);

    always_comb begin
        srtt_next      = srtt;
        rttvar_next    = rttvar;
        mrto_next      = mrto;
        erto_next      = erto;
        last_echo_next = last_echo;
        sample_used    = 1'b0;
        if (cmd == CMD_BACKOFF) begin
            // cap is below full scale, so backed always fits
            erto_next = backed[T-1:0];
        end else if (sample_ok) begin
            last_echo_next = echo_ticks;
            if (rtt_ok) begin
                srtt_next   = srtt_s;
                rttvar_next = var_s;
                mrto_next   = mrto_s;
                erto_next   = erto_s;
                sample_used = 1'b1;
            end
        end
    end

endmodule

// ===== design/rtt_rto_estimator_core.sv =====
// RTT / RTO estimator core (Jacobson/Karels style, times in whole ms).
// Input beats on s_*: tuser carries the command (sample or loss backoff),
// tdata the session flags and the echoed and current 16-bit tick stamps.
// Every input beat yields exactly one output beat on m_* carrying the
// smoothed rtt, its variation, the minimum and effective timeouts after
// the beat, plus a flag telling whether an rtt sample was taken.
// Flow: an accepted beat is held in the input register, the estimator
// update is done combinationally from it, and the result register is
// loaded when the input register advances; m_tvalid is the result valid.
// Throughput is one beat per cycle while m_tready stays high; the state
// update is combinational (its longest path is the 1.4142 backoff multiply).
// Stall: when m_tready is low with a result pending, a beat in the input
// register is held there and s_tready drops; nothing is lost or repeated.
// Reset (aresetn low, synchronous): estimate cleared, minimum timeout 250,
// effective timeout 3000, configuration registers back to their defaults.
// Config: cfg_we writes cfg_wdata into the register picked by cfg_index
// (0 margin, 1 floor, 2 cap, 3 initial erto: dropped); only write while idle.
module rtt_rto_estimator_core #(
    parameter int TIME_BITS = rtte_pkg::TIME_BITS_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // config write port
    input  logic                                  cfg_we,
    input  logic [rtte_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [rtte_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    // input beats
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // tdata, from bit 0: session_open, echo_present, echo_ticks[15:0],
    // now_ticks[15:0], zero pad
    input  logic [39:0]                           s_tdata,
    // tuser: cmd (0 rtt sample, 1 loss backoff)
    input  logic [0:0]                            s_tuser,
    // result beats
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // tdata, from bit 0: srtt_ms, rttvar_ms, mrto_ms, erto_ms (TIME_BITS
    // each), sample_used, zero pad to a whole byte
    output logic [((4*TIME_BITS+1+7)/8)*8-1:0]    m_tdata
);
    import rtte_pkg::*;

    localparam int T        = TIME_BITS;
    localparam int OUT_BITS = ((4*T+1+7)/8)*8;

    // configuration
    logic [MARGIN_BITS-1:0] margin_reg;
    logic [FLOOR_BITS-1:0]  floor_reg;
    logic [CAP_BITS-1:0]    cap_reg;

    // input register
    logic                   in_valid_reg;
    cmd_t                   cmd_reg;
    logic                   open_reg;
    logic                   present_reg;
    logic [TICK_BITS-1:0]   echo_reg;
    logic [TICK_BITS-1:0]   now_reg;

    // estimator state
    logic [T-1:0]           srtt_reg;
    logic [T-1:0]           rttvar_reg;
    logic [T-1:0]           mrto_reg;
    logic [T-1:0]           erto_reg;
    logic [TICK_BITS-1:0]   last_echo_reg;

    logic [T-1:0]           srtt_next;
    logic [T-1:0]           rttvar_next;
    logic [T-1:0]           mrto_next;
    logic [T-1:0]           erto_next;
    logic [TICK_BITS-1:0]   last_echo_next;
    logic                   used_next;

    // result register
    logic                   out_valid_reg;
    logic [OUT_BITS-1:0]    out_data_reg;

    logic                   advance;
    logic                   in_take;

    // input register moves on when the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Config writes. There is no initial erto register: the effective timeout
    // is reloaded with its default by reset alone, so a written value never
    // reaches the datapath; its writes are accepted and dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg <= MARGIN_RESET;
            floor_reg  <= FLOOR_RESET;
            cap_reg    <= CAP_RESET;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_RTO_MARGIN: margin_reg <= cfg_wdata[MARGIN_BITS-1:0];
                CFG_ERTO_FLOOR: floor_reg  <= cfg_wdata[FLOOR_BITS-1:0];
                CFG_ERTO_CAP:   cap_reg    <= cfg_wdata[CAP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            cmd_reg     <= cmd_t'(s_tuser);
            open_reg    <= s_tdata[0];
            present_reg <= s_tdata[1];
            echo_reg    <= s_tdata[17:2];
            now_reg     <= s_tdata[33:18];
        end
    end

    rtte_update #(
        .TIME_BITS (T)
    ) u_update (
        .cmd            (cmd_reg),
        .session_open   (open_reg),
        .echo_present   (present_reg),
        .echo_ticks     (echo_reg),
        .now_ticks      (now_reg),
        .srtt           (srtt_reg),
        .rttvar         (rttvar_reg),
        .mrto           (mrto_reg),
        .erto           (erto_reg),
        .last_echo      (last_echo_reg),
        .rto_margin     (margin_reg),
        .erto_floor     (floor_reg),
        .erto_cap       (cap_reg),
        .srtt_next      (srtt_next),
        .rttvar_next    (rttvar_next),
        .mrto_next      (mrto_next),
        .erto_next      (erto_next),
        .last_echo_next (last_echo_next),
        .sample_used    (used_next)
    );

    // estimator state, updated once per beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            srtt_reg      <= '0;
            rttvar_reg    <= '0;
            mrto_reg      <= T'(MRTO_RESET);
            erto_reg      <= T'(ERTO_RESET);
            last_echo_reg <= '0;
        end else if (advance) begin
            srtt_reg      <= srtt_next;
            rttvar_reg    <= rttvar_next;
            mrto_reg      <= mrto_next;
            erto_reg      <= erto_next;
            last_echo_reg <= last_echo_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= OUT_BITS'({used_next, erto_next, mrto_next,
                                       rttvar_next, srtt_next});
        end
    end

endmodule
